/* src/mqpd_pkg.sv */
// Shared types and constants of the multi-queue priority dequeue block.
// No dependencies; every other file of the block refers to it by scoped names.
package mqpd_pkg;

   // default sizes of the pool and of the queue set
   localparam int NUM_QUEUES_DEFAULT  = 8;
   localparam int NUM_ENTRIES_DEFAULT = 64;

   // fixed field widths of the item channels
   localparam int OP_W     = 2;
   localparam int QID_W    = 4;
   localparam int HANDLE_W = 6;
   localparam int STATUS_W = 3;
   localparam int SQ_W     = 3;
   localparam int DEPTH_W  = 7;
   localparam int RETRY_W  = 32;

   // operation codes
   typedef enum logic [OP_W-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_RETRY   = 2'd1,
      OP_REMOVE  = 2'd2,
      OP_POP     = 2'd3
   } op_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK         = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_MISMATCH   = 3'd2,
      ST_NOT_QUEUED = 3'd3,
      ST_ALREADY    = 3'd4
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clear;
      logic accept;
      logic exec;
      logic link;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic clear_last;
      logic exec_fail;
      logic out_free;
   } stat_type;

endpackage

/* src/mqpd_ifs.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on mqpd_pkg for the field widths.
interface mqpd_req_if;
   logic                          valid;
   logic                          ready;
   logic [mqpd_pkg::OP_W-1:0]     operation;
   logic [mqpd_pkg::QID_W-1:0]    queue_id;
   logic [mqpd_pkg::HANDLE_W-1:0] entry_handle;

   modport source (output valid, output operation, output queue_id, output entry_handle,
                   input ready);
   modport sink (input valid, input operation, input queue_id, input entry_handle,
                 output ready);
endinterface

interface mqpd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mqpd_pkg::STATUS_W-1:0] status;
   logic [mqpd_pkg::SQ_W-1:0]     served_queue;
   logic [mqpd_pkg::HANDLE_W-1:0] entry_out;
   logic [mqpd_pkg::DEPTH_W-1:0]  queue_depth;
   logic [mqpd_pkg::RETRY_W-1:0]  retry_count;
   logic                          drop_notice;
   logic                          work_notice;

   modport source (output valid, output status, output served_queue, output entry_out,
                   output queue_depth, output retry_count, output drop_notice,
                   output work_notice, input ready);
   modport sink (input valid, input status, input served_queue, input entry_out,
                 input queue_depth, input retry_count, input drop_notice,
                 input work_notice, output ready);
endinterface

/* src/mqpd_ctrl.sv */
// Sequencing state machine of the multi-queue priority dequeue block.
// Depends on mqpd_pkg for the command and status structs.
module mqpd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mqpd_pkg::stat_type stat,
   output mqpd_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_LINK
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (stat.out_free) state_in = stat.exec_fail ? S_IDLE : S_LINK;
         end
         S_LINK: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ready_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ready_ff <= (state_in == S_IDLE);
      end
   end

   // commands to the datapath
   assign req_ready  = ready_ff;
   assign cmd.clear  = (state_ff == S_CLEAR);
   assign cmd.accept = ready_ff && req_valid;
   assign cmd.exec   = (state_ff == S_EXEC) && stat.out_free;
   assign cmd.link   = (state_ff == S_LINK);

endmodule

/* src/mqpd_dpath.sv */
// Datapath: entry pool memories, per-queue head/tail/depth and the response register.
// Depends on mqpd_pkg and on the response interface in mqpd_ifs.
module mqpd_dpath #(
   parameter int NUM_QUEUES  = mqpd_pkg::NUM_QUEUES_DEFAULT,
   parameter int NUM_ENTRIES = mqpd_pkg::NUM_ENTRIES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mqpd_pkg::cmd_type             cmd,
   output mqpd_pkg::stat_type            stat,
   input  logic [mqpd_pkg::OP_W-1:0]     req_operation,
   input  logic [mqpd_pkg::QID_W-1:0]    req_queue_id,
   input  logic [mqpd_pkg::HANDLE_W-1:0] req_entry_handle,
   mqpd_rsp_if.source                    rsp
);

   localparam int EW = $clog2(NUM_ENTRIES);
   localparam int PW = $clog2(NUM_ENTRIES + 1);
   localparam int DW = $clog2(NUM_ENTRIES + 1);
   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
   localparam logic [PW-1:0] NIL = PW'(NUM_ENTRIES);

   // entry pool memories
   logic [PW-1:0]                prev_mem   [NUM_ENTRIES];
   logic [PW-1:0]                next_mem   [NUM_ENTRIES];
   logic [QW-1:0]                owner_mem  [NUM_ENTRIES];
   logic [mqpd_pkg::RETRY_W-1:0] retry_mem  [NUM_ENTRIES];
   logic                         queued_mem [NUM_ENTRIES];

   // per-queue pointers and depths
   logic [PW-1:0] head_ff  [NUM_QUEUES];
   logic [PW-1:0] tail_ff  [NUM_QUEUES];
   logic [DW-1:0] depth_ff [NUM_QUEUES];

   // item registers
   mqpd_pkg::op_type              op_ff;
   logic [mqpd_pkg::QID_W-1:0]    qid_ff;
   logic [mqpd_pkg::HANDLE_W-1:0] handle_ff;
   logic                          handle_ok_ff;
   logic                          pop_hit_ff;
   logic [QW-1:0]                 pop_q_ff;
   logic [EW-1:0]                 eidx_ff;

   // registered memory read data
   logic [PW-1:0]                prev_rd_ff;
   logic [PW-1:0]                next_rd_ff;
   logic [QW-1:0]                owner_rd_ff;
   logic [mqpd_pkg::RETRY_W-1:0] retry_rd_ff;
   logic                         queued_rd_ff;

   // neighbor link writes done in the link cycle
   logic          nlnk_en_ff;
   logic [EW-1:0] nlnk_addr_ff;
   logic [PW-1:0] nlnk_data_ff;
   logic          plnk_en_ff;
   logic [EW-1:0] plnk_addr_ff;
   logic [PW-1:0] plnk_data_ff;

   // clearing pass counter
   logic [EW-1:0] clr_ff;

   // response register
   logic                          rsp_valid_ff;
   mqpd_pkg::status_type          rsp_status_ff;
   logic [mqpd_pkg::SQ_W-1:0]     rsp_queue_ff;
   logic [mqpd_pkg::HANDLE_W-1:0] rsp_entry_ff;
   logic [mqpd_pkg::DEPTH_W-1:0]  rsp_depth_ff;
   logic [mqpd_pkg::RETRY_W-1:0]  rsp_retry_ff;
   logic                          rsp_drop_ff;
   logic                          rsp_work_ff;

   // combinational signals
   logic                         pop_hit;
   logic [QW-1:0]                pop_q;
   logic [QW-1:0]                hq_addr;
   logic [QW-1:0]                exec_q;
   logic [QW-1:0]                owner_cl;
   logic [PW-1:0]                q_head;
   logic [PW-1:0]                q_tail;
   logic [DW-1:0]                q_depth;
   logic [EW-1:0]                rd_addr;
   logic                         q_ok;
   logic                         p_valid;
   logic                         n_valid;
   logic                         h_valid;
   logic                         t_valid;
   logic [mqpd_pkg::RETRY_W-1:0] r_inc;
   logic                         do_unlink;
   logic                         do_enq;
   logic                         do_retry;
   logic                         fail;
   mqpd_pkg::status_type         res_status;
   logic [mqpd_pkg::HANDLE_W-1:0] res_entry;
   logic                         res_drop;
   logic                         res_work;
   logic [PW-1:0]                head_in;
   logic [PW-1:0]                tail_in;
   logic [DW-1:0]                depth_in;
   logic                         next_we;
   logic [EW-1:0]                next_wa;
   logic [PW-1:0]                next_wd;
   logic                         prev_we;
   logic [EW-1:0]                prev_wa;
   logic [PW-1:0]                prev_wd;
   logic                         queued_we;
   logic [EW-1:0]                queued_wa;
   logic                         queued_wd;
   logic                         owner_we;
   logic                         retry_we;
   logic [mqpd_pkg::RETRY_W-1:0] retry_wd;

   // first non-empty queue, queue 0 wins
   always_comb begin
      pop_hit = 1'b0;
      pop_q   = '0;
      for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
         if (depth_ff[i] != '0) begin
            pop_hit = 1'b1;
            pop_q   = QW'(i);
         end
      end
   end

   // one queue table address per cycle: pop lookup on accept, else the working queue
   assign hq_addr = cmd.accept ? pop_q : exec_q;
   assign q_head  = head_ff[hq_addr];
   assign q_tail  = tail_ff[hq_addr];
   assign q_depth = depth_ff[hq_addr];

   // pool read address: head of the chosen queue for a pop, else the given handle
   assign rd_addr = (mqpd_pkg::op_type'(req_operation) == mqpd_pkg::OP_POP) ?
                    EW'(q_head) : EW'(req_entry_handle);

   // capture the item
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff        <= mqpd_pkg::op_type'(req_operation);
         qid_ff       <= req_queue_id;
         handle_ff    <= req_entry_handle;
         handle_ok_ff <= (32'(req_entry_handle) < NUM_ENTRIES);
         pop_hit_ff   <= pop_hit;
         pop_q_ff     <= pop_q;
         eidx_ff      <= rd_addr;
      end
   end

   // pool reads, registered
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         prev_rd_ff   <= prev_mem[rd_addr];
         next_rd_ff   <= next_mem[rd_addr];
         owner_rd_ff  <= owner_mem[rd_addr];
         retry_rd_ff  <= retry_mem[rd_addr];
         queued_rd_ff <= queued_mem[rd_addr];
      end
   end

   // decode of the item against the fetched entry
   assign owner_cl = (32'(owner_rd_ff) < NUM_QUEUES) ? owner_rd_ff : '0;
   assign q_ok     = (32'(qid_ff) < NUM_QUEUES);
   assign exec_q   = (op_ff == mqpd_pkg::OP_POP)    ? pop_q_ff :
                     (op_ff == mqpd_pkg::OP_REMOVE) ? owner_cl : QW'(qid_ff);
   assign p_valid  = (32'(prev_rd_ff) < NUM_ENTRIES);
   assign n_valid  = (32'(next_rd_ff) < NUM_ENTRIES);
   assign h_valid  = (32'(q_head) < NUM_ENTRIES);
   assign t_valid  = (32'(q_tail) < NUM_ENTRIES);
   assign r_inc    = (retry_rd_ff == '1) ? retry_rd_ff : retry_rd_ff + 32'd1;

   always_comb begin
      do_unlink  = 1'b0;
      do_enq     = 1'b0;
      do_retry   = 1'b0;
      fail       = 1'b0;
      res_status = mqpd_pkg::ST_OK;
      res_entry  = handle_ff;
      res_drop   = 1'b0;
      res_work   = 1'b0;
      case (op_ff)
         mqpd_pkg::OP_POP: begin
            if (!pop_hit_ff) begin
               fail       = 1'b1;
               res_status = mqpd_pkg::ST_EMPTY;
               res_entry  = '0;
            end else begin
               do_unlink = 1'b1;
               res_work  = 1'b1;
               res_entry = mqpd_pkg::HANDLE_W'(eidx_ff);
            end
         end
         mqpd_pkg::OP_REMOVE: begin
            if (!handle_ok_ff || !queued_rd_ff) begin
               fail       = 1'b1;
               res_status = mqpd_pkg::ST_NOT_QUEUED;
            end else begin
               do_unlink = 1'b1;
               res_drop  = (32'(qid_ff) != 32'(owner_cl));
            end
         end
         mqpd_pkg::OP_ENQUEUE, mqpd_pkg::OP_RETRY: begin
            if (!handle_ok_ff) begin
               fail       = 1'b1;
               res_status = mqpd_pkg::ST_NOT_QUEUED;
            end else if (queued_rd_ff) begin
               fail       = 1'b1;
               res_status = mqpd_pkg::ST_ALREADY;
            end else if (!q_ok || (op_ff == mqpd_pkg::OP_RETRY &&
                                   32'(owner_rd_ff) != 32'(qid_ff))) begin
               fail       = 1'b1;
               res_status = mqpd_pkg::ST_MISMATCH;
            end else begin
               do_enq   = (op_ff == mqpd_pkg::OP_ENQUEUE);
               do_retry = (op_ff == mqpd_pkg::OP_RETRY);
            end
         end
         default: begin
            fail = 1'b1;
         end
      endcase
   end

   // new head, tail and depth of the working queue
   always_comb begin
      head_in  = q_head;
      tail_in  = q_tail;
      depth_in = q_depth;
      if (do_unlink) begin
         if (!p_valid) head_in = next_rd_ff;
         if (!n_valid) tail_in = prev_rd_ff;
         if (q_depth != '0) depth_in = q_depth - DW'(1);
      end else if (do_enq) begin
         if (!t_valid) head_in = PW'(eidx_ff);
         tail_in  = PW'(eidx_ff);
         depth_in = q_depth + DW'(1);
      end else if (do_retry) begin
         if (!h_valid) tail_in = PW'(eidx_ff);
         head_in  = PW'(eidx_ff);
         depth_in = q_depth + DW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_QUEUES; i++) begin
            head_ff[i]  <= NIL;
            tail_ff[i]  <= NIL;
            depth_ff[i] <= '0;
         end
      end else if (cmd.exec && (do_unlink || do_enq || do_retry)) begin
         head_ff[exec_q]  <= head_in;
         tail_ff[exec_q]  <= tail_in;
         depth_ff[exec_q] <= depth_in;
      end
   end

   // neighbor link updates for the following cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         nlnk_en_ff <= 1'b0;
         plnk_en_ff <= 1'b0;
      end else if (cmd.exec) begin
         nlnk_en_ff <= (do_unlink && p_valid) || (do_enq && t_valid);
         plnk_en_ff <= (do_unlink && n_valid) || (do_retry && h_valid);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         nlnk_addr_ff <= do_unlink ? EW'(prev_rd_ff) : EW'(q_tail);
         nlnk_data_ff <= do_unlink ? next_rd_ff : PW'(eidx_ff);
         plnk_addr_ff <= do_unlink ? EW'(next_rd_ff) : EW'(q_head);
         plnk_data_ff <= do_unlink ? prev_rd_ff : PW'(eidx_ff);
      end
   end

   // pool write ports: the entry itself on exec, its neighbors on link
   assign next_we   = (cmd.exec && (do_enq || do_retry)) || (cmd.link && nlnk_en_ff);
   assign next_wa   = cmd.link ? nlnk_addr_ff : eidx_ff;
   assign next_wd   = cmd.link ? nlnk_data_ff : (do_enq ? NIL : q_head);
   assign prev_we   = (cmd.exec && (do_enq || do_retry)) || (cmd.link && plnk_en_ff);
   assign prev_wa   = cmd.link ? plnk_addr_ff : eidx_ff;
   assign prev_wd   = cmd.link ? plnk_data_ff : (do_enq ? q_tail : NIL);
   assign owner_we  = cmd.exec && do_enq;
   assign retry_we  = cmd.exec && (do_enq || do_retry);
   assign retry_wd  = do_enq ? '0 : r_inc;
   assign queued_we = cmd.clear || (cmd.exec && (do_unlink || do_enq || do_retry));
   assign queued_wa = cmd.clear ? clr_ff : eidx_ff;
   assign queued_wd = !cmd.clear && !do_unlink;

   always_ff @(posedge clock) begin
      if (next_we) next_mem[next_wa] <= next_wd;
   end

   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
   end

   always_ff @(posedge clock) begin
      if (owner_we) owner_mem[eidx_ff] <= exec_q;
   end

   always_ff @(posedge clock) begin
      if (retry_we) retry_mem[eidx_ff] <= retry_wd;
   end

   always_ff @(posedge clock) begin
      if (queued_we) queued_mem[queued_wa] <= queued_wd;
   end

   // clearing pass over the queued flags after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + EW'(1);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rsp_status_ff <= res_status;
         rsp_entry_ff  <= res_entry;
         rsp_drop_ff   <= res_drop;
         rsp_work_ff   <= res_work;
         rsp_queue_ff  <= fail ? '0 : mqpd_pkg::SQ_W'(exec_q);
         rsp_depth_ff  <= fail ? '0 : mqpd_pkg::DEPTH_W'(depth_in);
         rsp_retry_ff  <= fail ? '0 : (do_unlink ? retry_rd_ff : retry_wd);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.served_queue = rsp_queue_ff;
   assign rsp.entry_out    = rsp_entry_ff;
   assign rsp.queue_depth  = rsp_depth_ff;
   assign rsp.retry_count  = rsp_retry_ff;
   assign rsp.drop_notice  = rsp_drop_ff;
   assign rsp.work_notice  = rsp_work_ff;

   // status to the controller
   assign stat.clear_last = (clr_ff == EW'(NUM_ENTRIES - 1));
   assign stat.exec_fail  = fail;
   assign stat.out_free   = !rsp_valid_ff || rsp.ready;

endmodule

/* src/multi_queue_priority_dequeue.sv */
// Multi-queue priority dequeue: linked-list queues over a shared entry pool.
// Depends on mqpd_pkg, mqpd_ifs, mqpd_ctrl and mqpd_dpath.
//
// Usage:
//  - req_chan carries one item per valid/ready handshake: operation, queue_id and
//    entry_handle (enqueue back, retry at front, remove, pop highest priority).
//  - rsp_chan returns exactly one result item per request item, in order.
//  - An item that changes a queue passes through accept, update of the queue
//    tables and the entry, and rewrite of the neighbor links; an item that
//    ends with an error status stops after the update. The link rewrite is its
//    own step since each pool link memory has a single write port: an entry and
//    its neighbor cannot be written in the same cycle. The result register
//    loads in the update step, which a result still waiting in it can hold back.
//  - The result sits in an output register; the next item is accepted while it
//    waits, and the block holds in its update cycle only if a new result is
//    ready while the old one has still not been taken.
//  - After reset a clearing pass walks every pool entry and clears its queued flag;
//    req_chan.ready stays low during it. All queues start empty.
//  - Reset is synchronous and active high.
module multi_queue_priority_dequeue #(
   parameter int NUM_QUEUES  = mqpd_pkg::NUM_QUEUES_DEFAULT,
   parameter int NUM_ENTRIES = mqpd_pkg::NUM_ENTRIES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   mqpd_req_if.sink   req_chan,
   mqpd_rsp_if.source rsp_chan
);

   mqpd_pkg::cmd_type  cmd;
   mqpd_pkg::stat_type stat;

   // sequencer
   mqpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // pool, queue tables and response register
   mqpd_dpath #(
      .NUM_QUEUES  (NUM_QUEUES),
      .NUM_ENTRIES (NUM_ENTRIES)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_chan.operation),
      .req_queue_id     (req_chan.queue_id),
      .req_entry_handle (req_chan.entry_handle),
      .rsp              (rsp_chan)
   );

   // controller issues at most one command per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.accept, cmd.exec, cmd.link}))
      else $error("more than one datapath command in a cycle");

   // a new result only appears after an update cycle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(cmd.exec))
      else $error("result valid without an update cycle");

   // one item at a time: no accept right after an accept
   assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> !req_chan.ready)
      else $error("ready high right after an accept");

   // no item is taken during the clearing pass
   assert property (@(posedge clock) disable iff (reset)
      cmd.clear |-> !req_chan.ready)
      else $error("ready high during the clearing pass");

endmodule

/* tb/mqpd_checker.sv */
`timescale 1ns / 100ps
// Scoreboard of the multi-queue priority dequeue: watches both item channels, keeps a
// shadow of the queue tables and the entry pool, and compares each result in order.
// Depends on mqpd_pkg and the channel interfaces of mqpd_ifs.
module mqpd_checker (
   input  logic clock,
   input  logic reset,
   mqpd_req_if  req_mon,
   mqpd_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   import mqpd_pkg::*;

   localparam int NQ = NUM_QUEUES_DEFAULT;
   localparam int NE = NUM_ENTRIES_DEFAULT;
   localparam logic [DEPTH_W-1:0] NO_LINK = DEPTH_W'(NE);
   localparam int REPORT_LIMIT = 10;

   // one result item as the block should return it
   typedef struct packed {
      status_type          status;
      logic [SQ_W-1:0]     served;
      logic [HANDLE_W-1:0] entry;
      logic [DEPTH_W-1:0]  depth;
      logic [RETRY_W-1:0]  retries;
      logic                drop;
      logic                work;
   } sched_result_type;

   // shadow of the queue tables and of the pool
   logic [DEPTH_W-1:0] head_of[NQ];
   logic [DEPTH_W-1:0] tail_of[NQ];
   logic [DEPTH_W-1:0] len_of[NQ];
   logic [DEPTH_W-1:0] prev_of[NE];
   logic [DEPTH_W-1:0] next_of[NE];
   logic [SQ_W-1:0]    owner_of[NE];
   logic               linked[NE];
   logic [RETRY_W-1:0] retries_of[NE];

   sched_result_type awaited_results[$];
   sched_result_type want;
   int               error_total = 0;

   assign fail_count = error_total;

   // take an entry out of its queue and mark it free
   function automatic void unlink_entry(logic [SQ_W-1:0] q, logic [HANDLE_W-1:0] e);
      logic [DEPTH_W-1:0] p;
      logic [DEPTH_W-1:0] n;
      p = prev_of[e];
      n = next_of[e];
      if (p != NO_LINK) next_of[p] = n;
      else head_of[q] = n;
      if (n != NO_LINK) prev_of[n] = p;
      else tail_of[q] = p;
      if (len_of[q] != '0) len_of[q] = len_of[q] - DEPTH_W'(1);
      prev_of[e] = NO_LINK;
      next_of[e] = NO_LINK;
      linked[e]  = 1'b0;
   endfunction

   // apply one request to the shadow and return the result it must give
   function automatic sched_result_type predict_result(op_type op, logic [QID_W-1:0] q,
                                                       logic [HANDLE_W-1:0] e);
      sched_result_type r;
      logic [DEPTH_W-1:0] h;
      logic [DEPTH_W-1:0] t;
      logic [SQ_W-1:0]    qs;
      r = '0;
      r.entry = e;
      qs = q[SQ_W-1:0];
      if (op == OP_POP) begin
         // lowest numbered non-empty queue wins
         r.status = ST_EMPTY;
         r.entry  = '0;
         for (int i = 0; i < NQ; i++) begin
            if (r.status == ST_EMPTY && head_of[i] != NO_LINK) begin
               h = head_of[i];
               unlink_entry(SQ_W'(i), h[HANDLE_W-1:0]);
               r.status  = ST_OK;
               r.served  = SQ_W'(i);
               r.entry   = h[HANDLE_W-1:0];
               r.depth   = len_of[i];
               r.retries = retries_of[h];
               r.work    = 1'b1;
            end
         end
      end else if (int'(e) >= NE) begin
         r.status = ST_NOT_QUEUED;
      end else if (op == OP_REMOVE) begin
         if (!linked[e]) begin
            r.status = ST_NOT_QUEUED;
         end else begin
            qs = owner_of[e];
            unlink_entry(qs, e);
            r.served  = qs;
            r.depth   = len_of[qs];
            r.retries = retries_of[e];
            r.drop    = (q != {1'b0, qs});
         end
      end else if (linked[e]) begin
         r.status = ST_ALREADY;
      end else if (q >= NQ || (op == OP_RETRY && {1'b0, owner_of[e]} != q)) begin
         r.status = ST_MISMATCH;
      end else begin
         if (op == OP_ENQUEUE) begin
            // append at the tail, fresh owner and retry count
            t = tail_of[qs];
            owner_of[e]   = qs;
            retries_of[e] = '0;
            next_of[e]    = NO_LINK;
            prev_of[e]    = t;
            if (t != NO_LINK) next_of[t] = DEPTH_W'(e);
            else head_of[qs] = DEPTH_W'(e);
            tail_of[qs] = DEPTH_W'(e);
         end else begin
            // retry goes in front, count saturates
            h = head_of[qs];
            if (retries_of[e] != '1) retries_of[e] = retries_of[e] + RETRY_W'(1);
            prev_of[e] = NO_LINK;
            next_of[e] = h;
            if (h != NO_LINK) prev_of[h] = DEPTH_W'(e);
            else tail_of[qs] = DEPTH_W'(e);
            head_of[qs] = DEPTH_W'(e);
         end
         linked[e]  = 1'b1;
         len_of[qs] = len_of[qs] + DEPTH_W'(1);
         r.served   = qs;
         r.depth    = len_of[qs];
         r.retries  = retries_of[e];
      end
      return r;
   endfunction

   function automatic void compare_field(string field, logic [RETRY_W-1:0] exp_val,
                                         logic [RETRY_W-1:0] act_val);
      if (act_val !== exp_val) begin
         error_total++;
         if (error_total <= REPORT_LIMIT)
            $display("%0t: result %s mismatch, expected %0h, actual %0h",
                     $time, field, exp_val, act_val);
      end
   endfunction

   // predict on each accepted request, check each accepted result
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NQ; i++) begin
            head_of[i] = NO_LINK;
            tail_of[i] = NO_LINK;
            len_of[i]  = '0;
         end
         for (int i = 0; i < NE; i++) begin
            prev_of[i]    = '0;
            next_of[i]    = '0;
            owner_of[i]   = '0;
            linked[i]     = 1'b0;
            retries_of[i] = '0;
         end
         awaited_results.delete();
         pending_count <= 0;
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            awaited_results.push_back(predict_result(op_type'(req_mon.operation),
                                                     req_mon.queue_id,
                                                     req_mon.entry_handle));
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
               error_total++;
               if (error_total <= REPORT_LIMIT)
                  $display("%0t: result item with none expected, status %0h entry %0h",
                           $time, rsp_mon.status, rsp_mon.entry_out);
            end else begin
               want = awaited_results.pop_front();
               compare_field("status", RETRY_W'(want.status),
                             RETRY_W'(rsp_mon.status));
               compare_field("served_queue", RETRY_W'(want.served),
                             RETRY_W'(rsp_mon.served_queue));
               compare_field("entry_out", RETRY_W'(want.entry),
                             RETRY_W'(rsp_mon.entry_out));
               compare_field("queue_depth", RETRY_W'(want.depth),
                             RETRY_W'(rsp_mon.queue_depth));
               compare_field("retry_count", want.retries, rsp_mon.retry_count);
               compare_field("drop_notice", RETRY_W'(want.drop),
                             RETRY_W'(rsp_mon.drop_notice));
               compare_field("work_notice", RETRY_W'(want.work),
                             RETRY_W'(rsp_mon.work_notice));
            end
         end
         pending_count <= awaited_results.size();
      end
   end

endmodule

/* tb/multi_queue_priority_dequeue_test.sv */
`timescale 1ns / 100ps
// Test top of the multi-queue priority dequeue: clock, reset, request stimulus and
// result back-pressure; the verdict comes from the failure count of mqpd_checker.
// Depends on mqpd_pkg, mqpd_ifs, multi_queue_priority_dequeue and mqpd_checker.
module multi_queue_priority_dequeue_test;
   import mqpd_pkg::*;

   localparam int NE              = NUM_ENTRIES_DEFAULT;
   localparam int NQ              = NUM_QUEUES_DEFAULT;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int MIXED_PER_PHASE = 280;
   localparam int SETTLE_CYCLES   = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   cycle_count    = 0;
   int   send_idle_pct  = 0;
   int   recv_stall_pct = 0;
   int   hold_requests  = 0;
   int   hold_served    = 0;
   int   hold_left      = 0;

   // entries offered for enqueue to a valid queue, and the owner last asked for
   bit              ever_owned[NE];
   bit [SQ_W-1:0]   owner_hint[NE];

   mqpd_req_if req_chan();
   mqpd_rsp_if rsp_chan();

   multi_queue_priority_dequeue i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mqpd_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random stalls, plus long hold-offs on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         rsp_chan.ready <= 1'b0;
         hold_served <= hold_served + 1;
         hold_left <= HOLD_OFF_CYCLES;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // offer one item after a random gap and wait until it is taken
   task automatic offer_request(op_type op, logic [QID_W-1:0] q, logic [HANDLE_W-1:0] e);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      if (op == OP_ENQUEUE && q < NQ) begin
         ever_owned[e] = 1'b1;
         owner_hint[e] = q[SQ_W-1:0];
      end
      req_chan.valid        <= 1'b1;
      req_chan.operation    <= op;
      req_chan.queue_id     <= q;
      req_chan.entry_handle <= e;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
   endtask

   task automatic pause_until_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // random mix of operations; retries only touch entries with a known owner
   task automatic issue_mixed_request();
      int                  pick;
      op_type              op;
      logic [QID_W-1:0]    q;
      logic [HANDLE_W-1:0] e;
      pick = $urandom_range(99);
      e = HANDLE_W'($urandom_range(NE - 1));
      if ($urandom_range(9) == 0) q = QID_W'($urandom_range(15));
      else q = QID_W'($urandom_range(NQ - 1));
      if (pick < 35) op = OP_ENQUEUE;
      else if (pick < 50) op = OP_RETRY;
      else if (pick < 70) op = OP_REMOVE;
      else op = OP_POP;
      if (op == OP_RETRY) begin
         if (!ever_owned[e]) op = OP_ENQUEUE;
         else if ($urandom_range(9) < 8) q = {1'b0, owner_hint[e]};
      end else if (op == OP_REMOVE && $urandom_range(1) == 1) begin
         q = {1'b0, owner_hint[e]};
      end
      offer_request(op, q, e);
   endtask

   // empty the pool, load all of it into one queue in random order, then pop it dry
   task automatic cycle_whole_pool(logic [SQ_W-1:0] target);
      logic [HANDLE_W-1:0] order[NE];
      logic [HANDLE_W-1:0] swap;
      int                  j;
      for (int i = 0; i < NE; i++) order[i] = HANDLE_W'(i);
      for (int i = NE - 1; i > 0; i--) begin
         j = $urandom_range(i);
         swap = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      for (int i = 0; i < NE; i++)
         offer_request(OP_REMOVE, QID_W'($urandom_range(15)), HANDLE_W'(i));
      for (int i = 0; i < NE; i++)
         offer_request(OP_ENQUEUE, {1'b0, target}, order[i]);
      repeat (NE + 1) offer_request(OP_POP, QID_W'($urandom), HANDLE_W'($urandom));
   endtask

   initial begin
      req_chan.valid        = 1'b0;
      req_chan.operation    = OP_ENQUEUE;
      req_chan.queue_id     = '0;
      req_chan.entry_handle = '0;
      rsp_chan.ready        = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, error codes, priority, retry at front, removes
      offer_request(OP_POP,     4'd0,  6'd0);
      offer_request(OP_REMOVE,  4'd0,  6'd0);
      offer_request(OP_ENQUEUE, 4'd0,  6'd0);
      offer_request(OP_ENQUEUE, 4'd3,  6'd0);
      offer_request(OP_RETRY,   4'd0,  6'd0);
      offer_request(OP_ENQUEUE, 4'd7,  6'd63);
      offer_request(OP_ENQUEUE, 4'd8,  6'd5);
      offer_request(OP_ENQUEUE, 4'd15, 6'd42);
      offer_request(OP_ENQUEUE, 4'd7,  6'd10);
      offer_request(OP_POP,     4'd9,  6'd33);
      offer_request(OP_RETRY,   4'd1,  6'd0);
      offer_request(OP_RETRY,   4'd0,  6'd0);
      offer_request(OP_POP,     4'd0,  6'd0);
      offer_request(OP_RETRY,   4'd12, 6'd0);
      offer_request(OP_RETRY,   4'd0,  6'd0);
      offer_request(OP_REMOVE,  4'd0,  6'd0);
      offer_request(OP_REMOVE,  4'd8,  6'd63);
      offer_request(OP_ENQUEUE, 4'd7,  6'd20);
      offer_request(OP_ENQUEUE, 4'd7,  6'd21);
      offer_request(OP_REMOVE,  4'd3,  6'd20);
      offer_request(OP_REMOVE,  4'd7,  6'd21);
      offer_request(OP_REMOVE,  4'd15, 6'd10);
      offer_request(OP_POP,     4'd15, 6'd63);
      pause_until_drained();

      // random phases with different idle and stall rates
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 61;
               recv_stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct <= 61;
            end
            default: begin
               send_idle_pct = 8;
               recv_stall_pct <= 8;
            end
         endcase
         if (phase == 0 || phase == 3)
            cycle_whole_pool(SQ_W'($urandom_range(NQ - 1)));
         for (int n = 0; n < MIXED_PER_PHASE; n++) begin
            // result side goes quiet while requests keep coming
            if (phase == 0 && n == 100) hold_requests <= hold_requests + 1;
            issue_mixed_request();
         end
         pause_until_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
